// ----- rtl/wsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int LENGTH_WIDTH_DEF = 63;

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_KEY    = 3'd3,
    PH_DATA   = 3'd4
  } phase_t;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_t;

  localparam logic [3:0] OPCODE_MASK = 4'hf;
  localparam logic [6:0] LEN7_EXT16  = 7'h7e;
  localparam logic [6:0] LEN7_EXT64  = 7'h7f;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    kind_t       kind;
    logic        final_flag;
    logic [3:0]  frame_opcode;
    logic        was_masked;
    logic [7:0]  payload_byte;
    logic        last;
  } wsd_res_t;

endpackage

// ----- rtl/wsd_in_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_in_reg
// Input register: holds one byte until the parser consumes it.
// ----------------------------------------------------------------------------
module wsd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       take,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);
  import wsd_pkg::*;

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_data_byte;
    end
  end

endmodule

// ----- rtl/wsd_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser
// Frame state machine: header decode, extended length, mask key and payload
// unmasking, one byte per step.
// ----------------------------------------------------------------------------
module wsd_parser #(
  parameter int LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  logic [7:0]              step_byte,
  output logic                    res_valid,
  output wsd_pkg::wsd_res_t       res,
  output logic [LENGTH_WIDTH-1:0] res_length
);
  import wsd_pkg::*;

  phase_t                  phase_r, phase_nxt;
  logic                    fin_r, fin_nxt;
  logic [3:0]              opcode_r, opcode_nxt;
  logic                    mask_r, mask_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt;
  logic [3:0]              cnt_r, cnt_nxt;
  logic [31:0]             key_r, key_nxt;
  logic [LENGTH_WIDTH-1:0] left_r, left_nxt;
  logic [1:0]              kidx_r, kidx_nxt;

  logic [6:0]              len7;
  logic                    ext_sel;
  logic [LENGTH_WIDTH-1:0] acc_shift;
  logic [3:0]              cnt_dec;
  logic                    cnt_done;
  logic [LENGTH_WIDTH-1:0] left_dec;
  logic                    left_zero;
  logic [7:0]              key_byte;
  logic                    hdr_done;
  logic [LENGTH_WIDTH-1:0] hdr_len;

  assign len7      = step_byte[6:0];
  assign ext_sel   = (len7 == LEN7_EXT16) || (len7 == LEN7_EXT64);
  assign acc_shift = {len_r[LENGTH_WIDTH-9:0], step_byte};
  assign cnt_dec   = cnt_r - 4'd1;
  assign cnt_done  = (cnt_dec == 4'd0);
  assign left_dec  = left_r - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
  assign left_zero = (left_dec == '0);

  always_comb begin
    case (kidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // header completion and the length it carries
  always_comb begin
    hdr_done = 1'b0;
    hdr_len  = len_r;
    case (phase_r)
      PH_HDR1: begin
        hdr_done = !ext_sel && !step_byte[7];
        hdr_len  = {{(LENGTH_WIDTH-7){1'b0}}, len7};
      end
      PH_EXTLEN: begin
        hdr_done = cnt_done && !mask_r;
        hdr_len  = acc_shift;
      end
      PH_KEY: begin
        hdr_done = cnt_done;
        hdr_len  = len_r;
      end
      default: begin
        hdr_done = 1'b0;
        hdr_len  = len_r;
      end
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HDR1: begin
        if (ext_sel) phase_nxt = PH_EXTLEN;
        else if (step_byte[7]) phase_nxt = PH_KEY;
        else phase_nxt = (hdr_len == '0) ? PH_HDR0 : PH_DATA;
      end
      PH_EXTLEN: begin
        if (cnt_done) begin
          if (mask_r) phase_nxt = PH_KEY;
          else phase_nxt = (hdr_len == '0) ? PH_HDR0 : PH_DATA;
        end
      end
      PH_KEY: begin
        if (cnt_done) phase_nxt = (hdr_len == '0) ? PH_HDR0 : PH_DATA;
      end
      PH_DATA: begin
        if (left_zero) phase_nxt = PH_HDR0;
      end
      default: phase_nxt = PH_HDR1;
    endcase
  end

  // datapath and result
  always_comb begin
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    left_nxt   = left_r;
    kidx_nxt   = kidx_r;
    res_valid  = 1'b0;
    res.kind         = KIND_HEADER;
    res.payload_byte = 8'h00;
    res.last         = 1'b0;
    case (phase_r)
      PH_HDR1: begin
        mask_nxt = step_byte[7];
        if (ext_sel) begin
          len_nxt = '0;
          cnt_nxt = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
        end else begin
          len_nxt = hdr_len;
          if (step_byte[7]) begin
            cnt_nxt = KEY_BYTES;
            key_nxt = '0;
          end
        end
      end
      PH_EXTLEN: begin
        len_nxt = acc_shift;
        cnt_nxt = cnt_dec;
        if (cnt_done && mask_r) begin
          cnt_nxt = KEY_BYTES;
          key_nxt = '0;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], step_byte};
        cnt_nxt = cnt_dec;
      end
      PH_DATA: begin
        kidx_nxt         = kidx_r + 2'd1;
        left_nxt         = left_dec;
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = step_byte ^ (mask_r ? key_byte : 8'h00);
        res.last         = left_zero;
      end
      default: begin
        fin_nxt    = step_byte[7];
        opcode_nxt = step_byte[3:0] & OPCODE_MASK;
      end
    endcase
    if (hdr_done) begin
      res_valid = 1'b1;
      res.kind  = KIND_HEADER;
      res.last  = (hdr_len == '0);
      left_nxt  = hdr_len;
      kidx_nxt  = 2'd0;
      cnt_nxt   = 4'd0;
    end
    res.final_flag   = fin_nxt;
    res.frame_opcode = opcode_nxt;
    res.was_masked   = mask_nxt;
    res_length       = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      fin_r    <= 1'b0;
      opcode_r <= 4'd0;
      mask_r   <= 1'b0;
      len_r    <= '0;
      cnt_r    <= 4'd0;
      key_r    <= 32'd0;
      left_r   <= '0;
      kidx_r   <= 2'd0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      key_r    <= key_nxt;
      left_r   <= left_nxt;
      kidx_r   <= kidx_nxt;
    end
  end

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Byte-wide WebSocket frame parser: one header result per frame, then one
// unmasked result per payload byte.
//
//   channel | ports                               | dir | transfer
//   --------+-------------------------------------+-----+------------------
//   in      | in_valid/in_ready, in_data_byte     | in  | one raw byte
//   out     | out_valid/out_ready, out_kind..last | out | header or payload
//
// One byte per cycle sustained while out_ready holds: input register, one
// pass through the frame state machine, result register. Header bytes that
// complete nothing give no result.
// Synchronous active-low reset clears the state machine and both registers.
// A stalled result register holds the byte in the input register and then
// deasserts in_ready; nothing is dropped.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_data_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_kind,
  output logic                    out_final_flag,
  output logic [3:0]              out_frame_opcode,
  output logic                    out_was_masked,
  output logic [LENGTH_WIDTH-1:0] out_frame_length,
  output logic [7:0]              out_payload_byte,
  output logic                    out_last
);
  import wsd_pkg::*;

  logic                    hold_valid;
  logic [7:0]              hold_byte;
  logic                    take;
  logic                    res_valid;
  wsd_res_t                res;
  logic [LENGTH_WIDTH-1:0] res_length;

  logic                    out_valid_r;
  wsd_res_t                out_res_r;
  logic [LENGTH_WIDTH-1:0] out_len_r;

  assign take = hold_valid && (!out_valid_r || out_ready);

  wsd_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .take         (take),
    .hold_valid   (hold_valid),
    .hold_byte    (hold_byte)
  );

  wsd_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (take),
    .step_byte  (hold_byte),
    .res_valid  (res_valid),
    .res        (res),
    .res_length (res_length)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_res_r <= res;
      out_len_r <= res_length;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_res_r.kind;
  assign out_final_flag   = out_res_r.final_flag;
  assign out_frame_opcode = out_res_r.frame_opcode;
  assign out_was_masked   = out_res_r.was_masked;
  assign out_frame_length = out_len_r;
  assign out_payload_byte = out_res_r.payload_byte;
  assign out_last         = out_res_r.last;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for websocket_frame_deframer. A fixed set of frames
// covering zero-length, masked, reserved-bit, 16-bit and wide 64-bit length
// cases is followed by random back-to-back frames, byte by byte. Every byte
// transfer is run through a frame decoder kept in the bench, and each result
// transfer is compared field by field against the oldest decoded result.
// Both channels stall in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_top;
  import wsd_pkg::*;

  localparam int LEN_W        = LENGTH_WIDTH_DEF;
  localparam int RANDOM_BYTES = 1150;
  localparam int TAIL_BYTES   = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  localparam int DIRECTED_LEN = 32;
  localparam logic [7:0] DIRECTED [DIRECTED_LEN] = '{
    8'h81, 8'h00,
    8'h7f, 8'h80, 8'hff, 8'hff, 8'hff, 8'hff,
    8'h82, 8'h82, 8'h01, 8'h02, 8'h04, 8'h08, 8'hff, 8'h00,
    8'h00, 8'h7e, 8'h00, 8'h01, 8'h55,
    8'h88, 8'h7f, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'ha5
  };

  typedef struct packed {
    kind_t            kind;
    logic             final_flag;
    logic [3:0]       opcode;
    logic             masked;
    logic [LEN_W-1:0] frame_len;
    logic [7:0]       data;
    logic             last_flag;
  } frame_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_data_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_kind;
  logic             out_final_flag;
  logic [3:0]       out_frame_opcode;
  logic             out_was_masked;
  logic [LEN_W-1:0] out_frame_length;
  logic [7:0]       out_payload_byte;
  logic             out_last;

  logic [7:0]    stream_bytes[$];
  frame_result_t decoded_results[$];
  int            bytes_accepted = 0;
  int            bytes_total = 0;
  int            error_count = 0;
  int            cycle_count = 0;

  // decoder state
  phase_t           hdr_phase = PH_HDR0;
  logic             fin_q = 1'b0;
  logic [3:0]       opcode_q = 4'h0;
  logic             mask_q = 1'b0;
  logic [LEN_W-1:0] len_acc = '0;
  logic [3:0]       hdr_left = 4'h0;
  logic [31:0]      key_q = '0;
  logic [LEN_W-1:0] remaining = '0;
  logic [1:0]       key_pos = 2'd0;

  websocket_frame_deframer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_final_flag   (out_final_flag),
    .out_frame_opcode (out_frame_opcode),
    .out_was_masked   (out_was_masked),
    .out_frame_length (out_frame_length),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last)
  );

  always #5 clk = ~clk;

  task automatic close_header();
    frame_result_t r;
    r = '{KIND_HEADER, fin_q, opcode_q, mask_q, len_acc, 8'h00, len_acc == '0};
    decoded_results.push_back(r);
    remaining = len_acc;
    key_pos = 2'd0;
    hdr_left = 4'h0;
    hdr_phase = (len_acc == '0) ? PH_HDR0 : PH_DATA;
  endtask

  task automatic length_known();
    if (mask_q) begin
      hdr_left = KEY_BYTES;
      key_q = '0;
      hdr_phase = PH_KEY;
    end else begin
      close_header();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    frame_result_t r;
    logic [7:0]    key_byte;
    case (hdr_phase)
      PH_HDR1: begin
        mask_q = b[7];
        if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64) begin
          len_acc = '0;
          hdr_left = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          hdr_phase = PH_EXTLEN;
        end else begin
          len_acc = LEN_W'(b[6:0]);
          length_known();
        end
      end
      PH_EXTLEN: begin
        len_acc = {len_acc[LEN_W-9:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'h0) length_known();
      end
      PH_KEY: begin
        key_q = {key_q[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'h0) close_header();
      end
      PH_DATA: begin
        key_byte = mask_q ? key_q[8*(3-key_pos) +: 8] : 8'h00;
        key_pos = key_pos + 2'd1;
        remaining = remaining - LEN_W'(1);
        r = '{KIND_PAYLOAD, fin_q, opcode_q, mask_q, len_acc, b ^ key_byte,
              remaining == '0};
        decoded_results.push_back(r);
        if (remaining == '0) hdr_phase = PH_HDR0;
      end
      default: begin
        fin_q = b[7];
        opcode_q = b[3:0] & OPCODE_MASK;
        hdr_phase = PH_HDR1;
      end
    endcase
  endtask

  // mostly short frames, a few long 16-bit ones; 64-bit lengths stay small
  // apart from the top bit, which the block drops
  task automatic push_random_frame();
    logic        masked;
    logic [15:0] plen;
    logic [31:0] key;
    int unsigned form;
    form = $urandom_range(0, 9);
    masked = ($urandom_range(0, 3) != 0);
    key = $urandom();
    if (form < 6)
      plen = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 125)
                                               : $urandom_range(0, 12));
    else if (form < 9)
      plen = 16'(($urandom_range(0, 15) == 0) ? $urandom_range(126, 400)
                                                : $urandom_range(0, 40));
    else
      plen = 16'($urandom_range(0, 20));
    stream_bytes.push_back(8'($urandom_range(0, 255)));
    if (form < 6) begin
      stream_bytes.push_back({masked, plen[6:0]});
    end else if (form < 9) begin
      stream_bytes.push_back({masked, LEN7_EXT16});
      stream_bytes.push_back(plen[15:8]);
      stream_bytes.push_back(plen[7:0]);
    end else begin
      stream_bytes.push_back({masked, LEN7_EXT64});
      stream_bytes.push_back({1'($urandom_range(0, 1)), 7'h00});
      repeat (5) stream_bytes.push_back(8'h00);
      stream_bytes.push_back(plen[15:8]);
      stream_bytes.push_back(plen[7:0]);
    end
    if (masked) begin
      stream_bytes.push_back(key[31:24]);
      stream_bytes.push_back(key[23:16]);
      stream_bytes.push_back(key[15:8]);
      stream_bytes.push_back(key[7:0]);
    end
    repeat (plen) stream_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // input driver
  int  src_gap = 0;
  logic src_idle_on = 1'b1;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_data_byte);
        bytes_accepted++;
      end
      if ($urandom_range(0, 299) == 0) src_idle_on = ~src_idle_on;
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (src_idle_on && stream_bytes.size() > TAIL_BYTES &&
                     $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(1, 17) - 1;
          in_valid <= 1'b0;
        end else if (stream_bytes.size() > 0) begin
          in_valid <= 1'b1;
          in_data_byte <= stream_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int  sink_gap = 0;
  logic sink_idle_on = 1'b1;
  always @(posedge clk) begin : result_monitor
    frame_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_results.size() == 0) begin
          $display("%0t: result transfer with none expected, kind %0d byte 0x%0h",
                   $time, out_kind, out_payload_byte);
          error_count++;
        end else begin
          want = decoded_results.pop_front();
          compare_field("kind", 64'(want.kind), 64'(out_kind));
          compare_field("final_flag", 64'(want.final_flag), 64'(out_final_flag));
          compare_field("frame_opcode", 64'(want.opcode), 64'(out_frame_opcode));
          compare_field("was_masked", 64'(want.masked), 64'(out_was_masked));
          compare_field("frame_length", 64'(want.frame_len), 64'(out_frame_length));
          compare_field("payload_byte", 64'(want.data), 64'(out_payload_byte));
          compare_field("last", 64'(want.last_flag), 64'(out_last));
        end
      end
      if ($urandom_range(0, 299) == 0) sink_idle_on = ~sink_idle_on;
      if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else if (sink_idle_on && stream_bytes.size() > TAIL_BYTES &&
                   $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    foreach (DIRECTED[i]) stream_bytes.push_back(DIRECTED[i]);
    while (stream_bytes.size() < DIRECTED_LEN + RANDOM_BYTES) push_random_frame();
    bytes_total = stream_bytes.size();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (bytes_accepted < bytes_total) @(posedge clk);
    while (decoded_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wsd_pkg.sv
rtl/wsd_in_reg.sv
rtl/wsd_parser.sv
rtl/websocket_frame_deframer.sv
tb/sv/tb_top.sv
